### rtl/core/cursor_motion_format_expander_assert.svh
// Assertion macros for the cursor motion format expander checkers.
// Clock is clk_i, reset is rst_ni (active low) in every user.
`ifndef CURSOR_MOTION_FORMAT_EXPANDER_ASSERT_SVH
`define CURSOR_MOTION_FORMAT_EXPANDER_ASSERT_SVH

// Plain clocked assertion, disabled while in reset.
`define CMFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication built on the plain form.
`define CMFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CMFE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### rtl/core/cmfe_pkg.sv
// ----------------------------------------------------------------------------
// cmfe_pkg
// Types and constants shared by the cursor motion format expander.
// ----------------------------------------------------------------------------
package cmfe_pkg;

  localparam int unsigned MaxBytes = 4;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_PCT    = 2'd1,
    MODE_PLUS   = 2'd2
  } mode_e;

  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_INC  = 8'h69;  // 'i'
  localparam logic [7:0] CH_REV  = 8'h72;  // 'r'
  localparam logic [7:0] CH_DEC  = 8'h64;  // 'd'
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NUL  = 8'h00;

  typedef logic [7:0] byte_t;

endpackage

### rtl/core/cursor_motion_format_expander.sv
// ----------------------------------------------------------------------------
// cursor_motion_format_expander
// Expands a cursor-motion template, one character per transaction, into
// escape-sequence bytes on a one-byte result channel.
// ----------------------------------------------------------------------------
// The first result byte is registered and is valid in the cycle after the input transaction.
// An item holds the result register while its bytes (1 to 4) leave one at a
//   time through the one-byte output port, stalling on out_ready_i; an item
//   with no bytes leaves the register empty.
// A new item is taken in the cycle its predecessor's last byte leaves.
// Reset (rst_ni low, async): parse state normal, line first, no increment,
//   result register empty.
module cursor_motion_format_expander (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] template_char_i,
  input  logic [8:0] target_col_i,
  input  logic [8:0] target_line_i,
  input  logic       template_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);
  import cmfe_pkg::*;

  mode_e       mode_q, mode_d;
  logic        arg_q, arg_d;
  logic        inc_q, inc_d;

  byte_t       buf_q [MaxBytes];
  byte_t       buf_d [MaxBytes];
  logic [1:0]  last_idx_q, last_idx_d;
  logic [1:0]  idx_q;
  logic        res_valid_q;

  logic        in_fire;
  logic        run_done;
  logic [2:0]  n;

  logic [9:0]  arg_val;
  logic [2:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  ones;

  assign run_done    = res_valid_q && out_ready_i && (idx_q == last_idx_q);
  assign in_ready_o  = !res_valid_q || run_done;
  assign in_fire     = in_valid_i && in_ready_o;

  assign out_valid_o = res_valid_q;
  assign out_byte_o  = buf_q[idx_q];
  assign run_last_o  = (idx_q == last_idx_q);

  // current argument plus increment, at most 512
  assign arg_val = (arg_q ? {1'b0, target_col_i} : {1'b0, target_line_i})
                 + {9'd0, inc_q};

  // decimal split: hundreds by compare chain, tens by reciprocal multiply
  always_comb begin
    if (arg_val >= 10'd500) begin
      hund = 3'd5;
      rem  = 7'(arg_val - 10'd500);
    end else if (arg_val >= 10'd400) begin
      hund = 3'd4;
      rem  = 7'(arg_val - 10'd400);
    end else if (arg_val >= 10'd300) begin
      hund = 3'd3;
      rem  = 7'(arg_val - 10'd300);
    end else if (arg_val >= 10'd200) begin
      hund = 3'd2;
      rem  = 7'(arg_val - 10'd200);
    end else if (arg_val >= 10'd100) begin
      hund = 3'd1;
      rem  = 7'(arg_val - 10'd100);
    end else begin
      hund = 3'd0;
      rem  = arg_val[6:0];
    end
  end

  assign tens_prod = {8'd0, rem} * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = {tens, 3'd0} + {2'd0, tens, 1'b0};
  assign ones      = 4'(rem - tens_x10);

  always_comb begin
    mode_d = mode_q;
    arg_d  = arg_q;
    inc_d  = inc_q;
    n      = 3'd0;
    for (int k = 0; k < MaxBytes; k++) begin
      buf_d[k] = CH_NUL;
    end

    case (mode_q)
      MODE_PCT: begin
        mode_d = MODE_NORMAL;
        case (template_char_i)
          CH_PLUS: mode_d = MODE_PLUS;
          CH_PCT: begin
            buf_d[0] = CH_PCT;
            n        = 3'd1;
          end
          CH_INC: inc_d = 1'b1;
          CH_REV: arg_d = 1'b1;
          CH_DEC: begin
            arg_d = !arg_q;
            if (hund != 3'd0) begin
              buf_d[0] = CH_ZERO + {5'd0, hund};
              buf_d[1] = CH_ZERO + {4'd0, tens};
              buf_d[2] = CH_ZERO + {4'd0, ones};
              n        = 3'd3;
            end else begin
              buf_d[0] = CH_ZERO + {4'd0, tens};
              buf_d[1] = CH_ZERO + {4'd0, ones};
              n        = 3'd2;
            end
          end
          default: ;  // unknown directive emits nothing
        endcase
      end
      MODE_PLUS: begin
        mode_d   = MODE_NORMAL;
        arg_d    = !arg_q;
        buf_d[0] = arg_val[7:0] + template_char_i;
        n        = 3'd1;
      end
      default: begin
        mode_d = MODE_NORMAL;
        if (template_char_i == CH_PCT) begin
          mode_d = MODE_PCT;
        end else begin
          buf_d[0] = template_char_i;
          n        = 3'd1;
        end
      end
    endcase

    // terminator; a dangling percent is simply dropped by the reset
    if (template_end_i) begin
      buf_d[n[1:0]] = CH_NUL;
      n             = n + 3'd1;
      mode_d        = MODE_NORMAL;
      arg_d         = 1'b0;
      inc_d         = 1'b0;
    end

    last_idx_d = 2'(n - 3'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      arg_q       <= 1'b0;
      inc_q       <= 1'b0;
      res_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      last_idx_q  <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_q      <= mode_d;
        arg_q       <= arg_d;
        inc_q       <= inc_d;
        res_valid_q <= (n != 3'd0);
        idx_q       <= 2'd0;
        last_idx_q  <= last_idx_d;
      end else if (run_done) begin
        res_valid_q <= 1'b0;
      end else if (res_valid_q && out_ready_i) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      buf_q <= buf_d;
    end
  end

endmodule

### rtl/core/cmfe_checker.sv
// ----------------------------------------------------------------------------
// cmfe_checker
// Port-level checks for the cursor motion format expander, bound to the top.
// ----------------------------------------------------------------------------
`include "cursor_motion_format_expander_assert.svh"

module cmfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       template_end_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o
);

  // a stalled result holds
  `CMFE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `CMFE_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_byte_o), "byte changed")

  // no new item while a result is stuck
  `CMFE_ASSERT(a_no_accept_stall, out_valid_o && !out_ready_i |-> !in_ready_o, "accept in stall")

  // bytes of one run are contiguous
  `CMFE_ASSERT_NEXT(a_run_cont, out_valid_o && out_ready_i && !run_last_o, out_valid_o,
                    "run broken")

  // end of template always yields at least the terminator
  `CMFE_ASSERT_NEXT(a_end_out, in_valid_i && in_ready_o && template_end_i, out_valid_o,
                    "terminator missing")

endmodule

bind cursor_motion_format_expander cmfe_checker u_cmfe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .template_end_i (template_end_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .run_last_o     (run_last_o)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the cursor motion format expander: templates go in one character
// per transaction, and each output byte is compared with a local expansion.
// ----------------------------------------------------------------------------
module tb;
  import cmfe_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandomItems = 386;

  typedef struct packed {
    byte_t      ch;
    logic [8:0] col;
    logic [8:0] line;
    logic       last;
  } tmpl_item_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } out_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid  = 1'b0;
  logic       in_ready_o;
  tmpl_item_t drv_item  = '0;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  byte_t      out_byte_o;
  logic       run_last_o;

  tmpl_item_t  pending_items[$];
  out_beat_t   expected_bytes[$];
  byte_t       tmpl_buf[$];
  int unsigned items_taken = 0;
  int unsigned total_items = 0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  logic        calm_phase;

  // expansion state
  mode_e fmt_mode    = MODE_NORMAL;
  logic  next_is_col = 1'b0;
  logic  add_one     = 1'b0;

  cursor_motion_format_expander i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .template_char_i(drv_item.ch),
    .target_col_i   (drv_item.col),
    .target_line_i  (drv_item.line),
    .template_end_i (drv_item.last),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // no idling on either side for a stretch in the middle of the run
  assign calm_phase = (items_taken >= 150) && (items_taken < 260);

  function automatic logic [9:0] take_coord(input tmpl_item_t it);
    logic [9:0] v;
    v = next_is_col ? {1'b0, it.col} : {1'b0, it.line};
    next_is_col = ~next_is_col;
    return v + add_one;
  endfunction

  task automatic expand_step(input tmpl_item_t it);
    byte_t      step_bytes[$];
    logic [9:0] v;
    case (fmt_mode)
      MODE_PCT: begin
        fmt_mode = MODE_NORMAL;
        case (it.ch)
          CH_PLUS: fmt_mode = MODE_PLUS;
          CH_PCT:  step_bytes.push_back(CH_PCT);
          CH_INC:  add_one = 1'b1;
          CH_REV:  next_is_col = 1'b1;
          CH_DEC: begin
            v = take_coord(it);
            if (v >= 100) begin
              step_bytes.push_back(byte_t'(CH_ZERO + v / 100));
              v = v % 100;
            end
            step_bytes.push_back(byte_t'(CH_ZERO + v / 10));
            step_bytes.push_back(byte_t'(CH_ZERO + v % 10));
          end
          default: ;  // unknown directive, nothing out
        endcase
      end
      MODE_PLUS: begin
        fmt_mode = MODE_NORMAL;
        v = take_coord(it);
        step_bytes.push_back(byte_t'(v + it.ch));
      end
      default: begin
        fmt_mode = MODE_NORMAL;
        if (it.ch == CH_PCT) fmt_mode = MODE_PCT;
        else step_bytes.push_back(it.ch);
      end
    endcase
    if (it.last) begin
      step_bytes.push_back(CH_NUL);
      fmt_mode    = MODE_NORMAL;
      next_is_col = 1'b0;
      add_one     = 1'b0;
    end
    foreach (step_bytes[k]) begin
      expected_bytes.push_back('{data: step_bytes[k], last: (k == step_bytes.size() - 1)});
    end
  endtask

  // Moves tmpl_buf into the pending queue; a few characters get their own
  // coordinates so the per-character sampling is exercised too.
  task automatic queue_template(input logic [8:0] col, input logic [8:0] line);
    tmpl_item_t it;
    foreach (tmpl_buf[k]) begin
      it.ch   = tmpl_buf[k];
      it.col  = col;
      it.line = line;
      if ($urandom_range(99) < 8) begin
        it.col  = 9'($urandom_range(511));
        it.line = 9'($urandom_range(511));
      end
      it.last = (k == tmpl_buf.size() - 1);
      pending_items.push_back(it);
    end
    tmpl_buf.delete();
  endtask

  function automatic logic [8:0] rand_coord();
    case ($urandom_range(3))
      0:       return 9'($urandom_range(9));
      1:       return 9'($urandom_range(110, 90));
      default: return 9'($urandom_range(511));
    endcase
  endfunction

  task automatic build_random_template();
    int unsigned n_tokens;
    n_tokens = $urandom_range(6, 1);
    repeat (n_tokens) begin
      case ($urandom_range(9))
        0, 1, 2: tmpl_buf.push_back(byte_t'($urandom_range(255)));
        3:       tmpl_buf = {tmpl_buf, CH_PCT, CH_PCT};
        4:       tmpl_buf = {tmpl_buf, CH_PCT, CH_INC};
        5:       tmpl_buf = {tmpl_buf, CH_PCT, CH_REV};
        6, 7:    tmpl_buf = {tmpl_buf, CH_PCT, CH_DEC};
        8:       tmpl_buf = {tmpl_buf, CH_PCT, CH_PLUS, byte_t'($urandom_range(255))};
        default: tmpl_buf = {tmpl_buf, CH_PCT, byte_t'($urandom_range(255))};
      endcase
    end
    // occasionally leave a directive open at the end
    case ($urandom_range(19))
      0:       tmpl_buf.push_back(CH_PCT);
      1:       tmpl_buf = {tmpl_buf, CH_PCT, CH_PLUS};
      default: ;
    endcase
    queue_template(rand_coord(), rand_coord());
  endtask

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expand_step(drv_item);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_items.size() != 0 && (calm_phase || $urandom_range(99) >= 28)) begin
          drv_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_beat;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output transaction: out_byte=%0h run_last=%0b",
                 out_byte_o, run_last_o);
          error_count++;
        end else begin
          exp_beat = expected_bytes.pop_front();
          if (out_byte_o !== exp_beat.data) begin
            $error("out_byte: expected %0h, got %0h", exp_beat.data, out_byte_o);
            error_count++;
          end
          if (run_last_o !== exp_beat.last) begin
            $error("run_last: expected %0b, got %0b", exp_beat.last, run_last_o);
            error_count++;
          end
        end
      end
      out_ready <= calm_phase || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    // increment, line 0 -> "01", column 511 -> "512" (four bytes on the end)
    tmpl_buf = {CH_PCT, CH_INC, CH_PCT, CH_DEC, 8'h3B, CH_PCT, CH_DEC};
    queue_template(9'd511, 9'd0);
    // reversed order, plus with 0xff wrapping, then line 511 as three digits
    tmpl_buf = {CH_PCT, CH_REV, CH_PCT, CH_PLUS, 8'hFF, CH_PCT, CH_DEC};
    queue_template(9'd255, 9'd511);
    // literal percent, unknown directive, percent left open at the end
    tmpl_buf = {CH_PCT, CH_PCT, CH_PCT, 8'h71, CH_PCT};
    queue_template(9'd7, 9'd3);
    // plus directive left open at the end
    tmpl_buf = {CH_PCT, CH_PLUS};
    queue_template(9'd100, 9'd99);
    // zero bytes: copied as plain, ignored after a percent
    tmpl_buf = {CH_NUL, CH_PCT, CH_NUL};
    queue_template(9'd0, 9'd0);

    while (pending_items.size() < RandomItems + 24) build_random_template();
    total_items = pending_items.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while ((items_taken < total_items || expected_bytes.size() != 0)
           && idle_cycles < StallLimit) @(posedge clk_i);

    if (idle_cycles >= StallLimit) begin
      $error("no transaction for %0d cycles", StallLimit);
      $display("simulation failed");
    end else begin
      repeat (DrainCycles) @(posedge clk_i);
      if (expected_bytes.size() != 0) begin
        $error("%0d expected output bytes never arrived", expected_bytes.size());
      end
      if (error_count == 0 && expected_bytes.size() == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
    end
    $finish;
  end

endmodule
